// ===== hw/rtl/shortest_arc_quaternion_assert.svh =====
// Assertion macros for the shortest-arc quaternion block.
// They sample on clk and stay quiet while rst_n is low.
`ifndef SHORTEST_ARC_QUATERNION_ASSERT_SVH
`define SHORTEST_ARC_QUATERNION_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SAQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/saq_pkg.sv =====
`timescale 1ns / 1ps

package saq_pkg;

    typedef struct packed {
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic signed [15:0] src_z;
        logic signed [15:0] dst_x;
        logic signed [15:0] dst_y;
        logic signed [15:0] dst_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic [1:0]         case_taken;
    } out_item_t;

    localparam logic [1:0] CASE_ALIGNED  = 2'd0;
    localparam logic [1:0] CASE_OPPOSITE = 2'd1;
    localparam logic [1:0] CASE_ARC      = 2'd2;

    localparam logic [15:0]        OPP_MARGIN_RESET = 16'd1074;
    localparam logic signed [15:0] ONE_Q14          = 16'sd16384;
    localparam logic signed [15:0] NEG_ONE_Q14      = -16'sd16384;
    localparam logic signed [31:0] ONE_Q30          = 32'sh4000_0000;

    // one root bit per square-root stage, one quotient bit per divider stage
    localparam int SQ_STEPS   = 32;
    localparam int DIV_STEPS  = 31;
    localparam int PIPE_DEPTH = 2 * SQ_STEPS + 2 * DIV_STEPS + 12;

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] low;
        logic [31:0] den;
        logic [30:0] q;
        logic        neg;
    } dv_t;

    function automatic sq_t sqrt_step(input sq_t s);
        logic [34:0] r;
        logic [34:0] t;
        sq_t         n;
        r      = {s.rem[32:0], s.rad[63:62]};
        t      = {1'b0, s.root, 2'b01};
        n.rad  = {s.rad[61:0], 2'b00};
        if (r >= t)
        begin
            n.rem  = r - t;
            n.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            n.rem  = r;
            n.root = {s.root[30:0], 1'b0};
        end
        return n;
    endfunction

    // top of the numerator must already sit below the divisor
    function automatic dv_t div_init(input logic [60:0] num, input logic [31:0] den,
                                     input logic neg);
        dv_t n;
        n.rem = {2'b00, num[60:31]};
        n.low = num[30:0];
        n.den = den;
        n.q   = '0;
        n.neg = neg;
        return n;
    endfunction

    function automatic dv_t div_step(input dv_t s);
        logic [32:0] r;
        logic [32:0] diff;
        dv_t         n;
        r     = {s.rem, s.low[30]};
        diff  = r - {1'b0, s.den};
        n     = s;
        n.low = {s.low[29:0], 1'b0};
        if (r >= {1'b0, s.den})
        begin
            n.rem = diff[31:0];
            n.q   = {s.q[29:0], 1'b1};
        end
        else
        begin
            n.rem = r[31:0];
            n.q   = {s.q[29:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic [15:0] abs16(input logic signed [15:0] x);
        return x[15] ? 16'd0 - x : x;
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] x);
        return x[32] ? 33'd0 - x : x;
    endfunction

    function automatic logic signed [31:0] apply_sign(input logic neg, input logic [30:0] mag);
        logic [31:0] m;
        m = {1'b0, mag};
        return neg ? $signed(32'd0 - m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] sat14(input logic neg, input logic [30:0] mag);
        logic [15:0] m;
        m = (mag > 31'd16384) ? 16'd16384 : mag[15:0];
        return neg ? $signed(16'd0 - m) : $signed(m);
    endfunction

    // divide by 2^30, nearest, halves away from zero
    function automatic logic signed [31:0] round_q30(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] r;
        mag = x[63] ? 64'd0 - x : x;
        r   = (mag + 64'h2000_0000) >> 30;
        return x[63] ? $signed(32'd0 - r[31:0]) : $signed(r[31:0]);
    endfunction

endpackage

// ===== hw/rtl/shortest_arc_quaternion.sv =====
// Shortest-arc rotation quaternion, fully pipelined.
// Throughput: one item per clock unless out_stall holds the output; two 32-stage square-root
// units and two 31-stage dividers, each retiring one bit per stage, make up most of the depth.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the margin to 1074.
`timescale 1ns / 1ps
`include "shortest_arc_quaternion_assert.svh"

module shortest_arc_quaternion (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  saq_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output saq_pkg::out_item_t  out_item
);
    import saq_pkg::*;

    typedef struct packed {
        in_item_t vec;
        logic     zero_a;
        logic     zero_b;
    } side1_t;

    typedef struct packed {
        logic zero_a;
        logic zero_b;
        logic yz_zero;
        logic a0_pos;
    } side2_t;

    typedef struct packed {
        logic [1:0]         code;
        logic signed [32:0] w;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [15:0] opp_y;
        logic signed [15:0] opp_z;
    } side3_t;

    typedef struct packed {
        logic [1:0]         code;
        logic               degen;
        logic signed [15:0] opp_y;
        logic signed [15:0] opp_z;
    } side4_t;

    logic [15:0]           margin_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  pipe_en;

    in_item_t    in_reg;
    in_item_t    vec1_reg;
    logic [31:0] sqa_reg [0:2];
    logic [31:0] sqb_reg [0:2];

    sq_t    sq1_reg   [0:SQ_STEPS][0:2];
    side1_t side1_reg [0:SQ_STEPS];
    sq_t    sq1_next  [0:2];
    side1_t side1_next;
    logic [31:0] n2a_c, n2b_c, n2yz_c;

    dv_t    dv1_reg   [0:DIV_STEPS][0:7];
    side2_t side2_reg [0:DIV_STEPS];
    dv_t    dv1_next  [0:7];
    side2_t side2_next;

    logic signed [31:0] u_reg [0:2];
    logic signed [31:0] v_reg [0:2];
    logic signed [31:0] u_next [0:2];
    logic signed [31:0] v_next [0:2];
    logic signed [15:0] opp_y_reg [0:4];
    logic signed [15:0] opp_z_reg [0:4];
    logic signed [15:0] opp_y_next, opp_z_next;

    logic signed [63:0] pd_reg [0:2];
    logic signed [63:0] pc_reg [0:5];
    logic signed [63:0] dot_reg;
    logic signed [63:0] cr_reg [0:2];
    logic signed [31:0] d_reg;
    logic signed [31:0] c_reg [0:2];

    logic [1:0]         code_reg;
    logic signed [32:0] w_reg;
    logic signed [31:0] cm_reg [0:2];
    logic [63:0]        sqc_reg [0:2];
    logic [63:0]        sqw_reg;
    logic [1:0]         code_c;
    logic signed [32:0] w_c;
    logic signed [33:0] lim_c;

    sq_t    sq2_reg   [0:SQ_STEPS];
    side3_t side3_reg [0:SQ_STEPS];
    sq_t    sq2_next;
    side3_t side3_next;

    dv_t    dv2_reg   [0:DIV_STEPS][0:3];
    side4_t side4_reg [0:DIV_STEPS];
    dv_t    dv2_next  [0:3];
    side4_t side4_next;

    out_item_t out_item_reg;
    out_item_t out_item_next;

    // whole pipeline moves together unless the output item is held
    assign pipe_en   = !(vld_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall  = !pipe_en;
    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= OPP_MARGIN_RESET;
            vld_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                margin_reg <= cfg_data;
            end
            if (pipe_en)
            begin
                vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
            end
        end
    end

    // squared lengths and first radicands
    always_comb
    begin
        n2a_c  = sqa_reg[0] + sqa_reg[1] + sqa_reg[2];
        n2b_c  = sqb_reg[0] + sqb_reg[1] + sqb_reg[2];
        n2yz_c = sqa_reg[1] + sqa_reg[2];
        sq1_next[0].rad  = {2'b00, n2a_c, 30'd0};
        sq1_next[1].rad  = {2'b00, n2b_c, 30'd0};
        sq1_next[2].rad  = {4'd0, n2yz_c, 28'd0};
        for (int l = 0; l < 3; l++)
        begin
            sq1_next[l].rem  = '0;
            sq1_next[l].root = '0;
        end
        side1_next.vec    = vec1_reg;
        side1_next.zero_a = (n2a_c == 32'd0);
        side1_next.zero_b = (n2b_c == 32'd0);
    end

    // normalise: numerator scaled, plus half the length for rounding
    always_comb
    begin
        logic [31:0] la, lb, lyz;
        in_item_t    s;
        la  = sq1_reg[SQ_STEPS][0].root;
        lb  = sq1_reg[SQ_STEPS][1].root;
        lyz = sq1_reg[SQ_STEPS][2].root;
        s   = side1_reg[SQ_STEPS].vec;
        dv1_next[0] = div_init({abs16(s.src_x), 45'd0} + {30'd0, la[31:1]}, la, s.src_x[15]);
        dv1_next[1] = div_init({abs16(s.src_y), 45'd0} + {30'd0, la[31:1]}, la, s.src_y[15]);
        dv1_next[2] = div_init({abs16(s.src_z), 45'd0} + {30'd0, la[31:1]}, la, s.src_z[15]);
        dv1_next[3] = div_init({abs16(s.dst_x), 45'd0} + {30'd0, lb[31:1]}, lb, s.dst_x[15]);
        dv1_next[4] = div_init({abs16(s.dst_y), 45'd0} + {30'd0, lb[31:1]}, lb, s.dst_y[15]);
        dv1_next[5] = div_init({abs16(s.dst_z), 45'd0} + {30'd0, lb[31:1]}, lb, s.dst_z[15]);
        // half-turn axis is X cross source: (0, -a_z, a_y)
        dv1_next[6] = div_init({17'd0, abs16(s.src_z), 28'd0} + {30'd0, lyz[31:1]}, lyz,
                               !s.src_z[15] && (s.src_z != 16'sd0));
        dv1_next[7] = div_init({17'd0, abs16(s.src_y), 28'd0} + {30'd0, lyz[31:1]}, lyz,
                               s.src_y[15]);
        side2_next.zero_a  = side1_reg[SQ_STEPS].zero_a;
        side2_next.zero_b  = side1_reg[SQ_STEPS].zero_b;
        side2_next.yz_zero = (s.src_y == 16'sd0) && (s.src_z == 16'sd0);
        side2_next.a0_pos  = !s.src_x[15] && (s.src_x != 16'sd0);
    end

    always_comb
    begin
        side2_t s;
        s = side2_reg[DIV_STEPS];
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = s.zero_a ? 32'sd0 :
                        apply_sign(dv1_reg[DIV_STEPS][i].neg, dv1_reg[DIV_STEPS][i].q);
            v_next[i] = s.zero_b ? 32'sd0 :
                        apply_sign(dv1_reg[DIV_STEPS][i+3].neg, dv1_reg[DIV_STEPS][i+3].q);
        end
        if (s.yz_zero)
        begin
            // source along X: fall back to Y cross source
            opp_y_next = 16'sd0;
            opp_z_next = s.a0_pos ? NEG_ONE_Q14 : ONE_Q14;
        end
        else
        begin
            opp_y_next = sat14(dv1_reg[DIV_STEPS][6].neg, dv1_reg[DIV_STEPS][6].q);
            opp_z_next = sat14(dv1_reg[DIV_STEPS][7].neg, dv1_reg[DIV_STEPS][7].q);
        end
    end

    // case selection and w = 1 + d
    always_comb
    begin
        logic signed [33:0] d34;
        d34   = {{2{d_reg[31]}}, d_reg};
        lim_c = $signed({18'd0, margin_reg}) - 34'sh0_4000_0000;
        w_c   = {d_reg[31], d_reg} + 33'sh0_4000_0000;
        if (d_reg >= ONE_Q30)
        begin
            code_c = CASE_ALIGNED;
        end
        else if (d34 < lim_c)
        begin
            code_c = CASE_OPPOSITE;
        end
        else
        begin
            code_c = CASE_ARC;
        end
    end

    always_comb
    begin
        sq2_next.rad  = sqc_reg[0] + sqc_reg[1] + sqc_reg[2] + sqw_reg;
        sq2_next.rem  = '0;
        sq2_next.root = '0;
        side3_next.code  = code_reg;
        side3_next.w     = w_reg;
        side3_next.c0    = cm_reg[0];
        side3_next.c1    = cm_reg[1];
        side3_next.c2    = cm_reg[2];
        side3_next.opp_y = opp_y_reg[4];
        side3_next.opp_z = opp_z_reg[4];
    end

    always_comb
    begin
        logic [31:0] len;
        side3_t      s;
        len = sq2_reg[SQ_STEPS].root;
        s   = side3_reg[SQ_STEPS];
        dv2_next[0] = div_init({14'd0, abs33(s.w), 14'd0} + {30'd0, len[31:1]}, len, s.w[32]);
        dv2_next[1] = div_init({14'd0, abs33({s.c0[31], s.c0}), 14'd0} + {30'd0, len[31:1]},
                               len, s.c0[31]);
        dv2_next[2] = div_init({14'd0, abs33({s.c1[31], s.c1}), 14'd0} + {30'd0, len[31:1]},
                               len, s.c1[31]);
        dv2_next[3] = div_init({14'd0, abs33({s.c2[31], s.c2}), 14'd0} + {30'd0, len[31:1]},
                               len, s.c2[31]);
        side4_next.code  = s.code;
        side4_next.degen = (len == 32'd0);
        side4_next.opp_y = s.opp_y;
        side4_next.opp_z = s.opp_z;
    end

    always_comb
    begin
        side4_t s;
        s = side4_reg[DIV_STEPS];
        out_item_next.quat_w     = ONE_Q14;
        out_item_next.quat_x     = 16'sd0;
        out_item_next.quat_y     = 16'sd0;
        out_item_next.quat_z     = 16'sd0;
        out_item_next.case_taken = s.code;
        unique case (s.code)
            CASE_ALIGNED:
            begin
                out_item_next.quat_w = ONE_Q14;
            end
            CASE_OPPOSITE:
            begin
                out_item_next.quat_w = 16'sd0;
                out_item_next.quat_y = s.opp_y;
                out_item_next.quat_z = s.opp_z;
            end
            CASE_ARC:
            begin
                if (!s.degen)
                begin
                    out_item_next.quat_w = sat14(dv2_reg[DIV_STEPS][0].neg,
                                                 dv2_reg[DIV_STEPS][0].q);
                    out_item_next.quat_x = sat14(dv2_reg[DIV_STEPS][1].neg,
                                                 dv2_reg[DIV_STEPS][1].q);
                    out_item_next.quat_y = sat14(dv2_reg[DIV_STEPS][2].neg,
                                                 dv2_reg[DIV_STEPS][2].q);
                    out_item_next.quat_z = sat14(dv2_reg[DIV_STEPS][3].neg,
                                                 dv2_reg[DIV_STEPS][3].q);
                end
            end
            default:
            begin
                out_item_next.case_taken = CASE_ALIGNED;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            in_reg   <= in_item;
            vec1_reg <= in_reg;
            sqa_reg[0] <= in_reg.src_x * in_reg.src_x;
            sqa_reg[1] <= in_reg.src_y * in_reg.src_y;
            sqa_reg[2] <= in_reg.src_z * in_reg.src_z;
            sqb_reg[0] <= in_reg.dst_x * in_reg.dst_x;
            sqb_reg[1] <= in_reg.dst_y * in_reg.dst_y;
            sqb_reg[2] <= in_reg.dst_z * in_reg.dst_z;

            side1_reg[0] <= side1_next;
            for (int l = 0; l < 3; l++)
            begin
                sq1_reg[0][l] <= sq1_next[l];
            end
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                side1_reg[k] <= side1_reg[k-1];
                for (int l = 0; l < 3; l++)
                begin
                    sq1_reg[k][l] <= sqrt_step(sq1_reg[k-1][l]);
                end
            end

            side2_reg[0] <= side2_next;
            for (int l = 0; l < 8; l++)
            begin
                dv1_reg[0][l] <= dv1_next[l];
            end
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                side2_reg[k] <= side2_reg[k-1];
                for (int l = 0; l < 8; l++)
                begin
                    dv1_reg[k][l] <= div_step(dv1_reg[k-1][l]);
                end
            end

            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= u_next[i];
                v_reg[i] <= v_next[i];
            end
            opp_y_reg[0] <= opp_y_next;
            opp_z_reg[0] <= opp_z_next;
            for (int k = 1; k < 5; k++)
            begin
                opp_y_reg[k] <= opp_y_reg[k-1];
                opp_z_reg[k] <= opp_z_reg[k-1];
            end

            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= u_reg[i] * v_reg[i];
            end
            pc_reg[0] <= u_reg[1] * v_reg[2];
            pc_reg[1] <= u_reg[2] * v_reg[1];
            pc_reg[2] <= u_reg[2] * v_reg[0];
            pc_reg[3] <= u_reg[0] * v_reg[2];
            pc_reg[4] <= u_reg[0] * v_reg[1];
            pc_reg[5] <= u_reg[1] * v_reg[0];

            dot_reg   <= pd_reg[0] + pd_reg[1] + pd_reg[2];
            cr_reg[0] <= pc_reg[0] - pc_reg[1];
            cr_reg[1] <= pc_reg[2] - pc_reg[3];
            cr_reg[2] <= pc_reg[4] - pc_reg[5];

            d_reg <= round_q30(dot_reg);
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= round_q30(cr_reg[i]);
            end

            code_reg <= code_c;
            w_reg    <= w_c;
            // w lies in [0, 2^31) whenever the arc path is taken
            sqw_reg  <= w_c[31:0] * w_c[31:0];
            for (int i = 0; i < 3; i++)
            begin
                cm_reg[i]  <= c_reg[i];
                sqc_reg[i] <= c_reg[i] * c_reg[i];
            end

            sq2_reg[0]   <= sq2_next;
            side3_reg[0] <= side3_next;
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                sq2_reg[k]   <= sqrt_step(sq2_reg[k-1]);
                side3_reg[k] <= side3_reg[k-1];
            end

            side4_reg[0] <= side4_next;
            for (int l = 0; l < 4; l++)
            begin
                dv2_reg[0][l] <= dv2_next[l];
            end
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                side4_reg[k] <= side4_reg[k-1];
                for (int l = 0; l < 4; l++)
                begin
                    dv2_reg[k][l] <= div_step(dv2_reg[k-1][l]);
                end
            end

            out_item_reg <= out_item_next;
        end
    end

    `SAQ_ASSERT_NOW(a_aligned_identity, out_valid && out_item.case_taken == CASE_ALIGNED, out_item.quat_w == ONE_Q14 && out_item.quat_x == 16'sd0 && out_item.quat_y == 16'sd0 && out_item.quat_z == 16'sd0, "aligned item is not the identity")
    `SAQ_ASSERT_NOW(a_opposite_axis, out_valid && out_item.case_taken == CASE_OPPOSITE, out_item.quat_w == 16'sd0 && out_item.quat_x == 16'sd0, "half-turn item has w or x set")
    `SAQ_ASSERT_NOW(a_arc_w_sign, out_valid && out_item.case_taken == CASE_ARC, !out_item.quat_w[15], "arc item has negative w")
    `SAQ_ASSERT_NEXT(a_pipe_hold, !pipe_en, $stable(vld_reg), "pipeline moved while output held")

endmodule
